// ===== sv/ncc_pkg.sv =====
// Package for the notification condition check block.
// Holds register codes, enable bit positions and the configuration struct.
// No dependencies; ncc_cfg_regs, ncc_decide and notify_condition_check use it.
package ncc_pkg;

	// Widths of the APB-style configuration port.
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	// Register index codes, taken from paddr[4:2].
	localparam logic [2:0] REG_ENABLE_MASK    = 3'd0;
	localparam logic [2:0] REG_MIN_PERIOD     = 3'd1;
	localparam logic [2:0] REG_MAX_PERIOD     = 3'd2;
	localparam logic [2:0] REG_CHANGE_STEP    = 3'd3;
	localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd4;
	localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd5;

	// Bit positions inside enable_mask.
	localparam int unsigned EN_PMIN = 0;
	localparam int unsigned EN_PMAX = 1;
	localparam int unsigned EN_STEP = 2;
	localparam int unsigned EN_LT   = 3;
	localparam int unsigned EN_GT   = 4;

	// Reset values of the registers.
	localparam logic [4:0]  ENABLE_MASK_RST = 5'd0;
	localparam logic [31:0] MIN_PERIOD_RST  = 32'd1;
	localparam logic [31:0] MAX_PERIOD_RST  = 32'd1;

	typedef struct packed {
		logic [4:0]         enable_mask;
		logic [31:0]        min_period;
		logic [31:0]        max_period;
		logic [30:0]        change_step;
		logic signed [31:0] low_threshold;
		logic signed [31:0] high_threshold;
	} cfg_t;

endpackage

// ===== sv/ncc_if.sv =====
// Valid/ready channel interfaces for the notification condition check block.
// One carries input ticks, the other the decisions. No dependencies.
interface ncc_in_if;
	logic               valid;
	logic               ready;
	logic [31:0]        now_seconds;
	logic signed [31:0] sample_value;

	modport source (output valid, output now_seconds, output sample_value, input ready);
	modport sink (input valid, input now_seconds, input sample_value, output ready);
endinterface

interface ncc_out_if;
	logic valid;
	logic ready;
	logic notify;

	modport source (output valid, output notify, input ready);
	modport sink (input valid, input notify, output ready);
endinterface

// ===== sv/ncc_cfg_regs.sv =====
// APB-style register file of the notification condition check block.
// Depends on ncc_pkg for register codes, reset values and cfg_t.
module ncc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ncc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ncc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ncc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output ncc_pkg::cfg_t                  cfg
);

	ncc_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask    <= ncc_pkg::ENABLE_MASK_RST;
			cfg_q.min_period     <= ncc_pkg::MIN_PERIOD_RST;
			cfg_q.max_period     <= ncc_pkg::MAX_PERIOD_RST;
			cfg_q.change_step    <= '0;
			cfg_q.low_threshold  <= '0;
			cfg_q.high_threshold <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				ncc_pkg::REG_ENABLE_MASK:    cfg_q.enable_mask    <= pwdata[4:0];
				ncc_pkg::REG_MIN_PERIOD:     cfg_q.min_period     <= pwdata;
				ncc_pkg::REG_MAX_PERIOD:     cfg_q.max_period     <= pwdata;
				ncc_pkg::REG_CHANGE_STEP:    cfg_q.change_step    <= pwdata[30:0];
				ncc_pkg::REG_LOW_THRESHOLD:  cfg_q.low_threshold  <= $signed(pwdata);
				ncc_pkg::REG_HIGH_THRESHOLD: cfg_q.high_threshold <= $signed(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ncc_pkg::REG_ENABLE_MASK:    prdata = {27'd0, cfg_q.enable_mask};
			ncc_pkg::REG_MIN_PERIOD:     prdata = cfg_q.min_period;
			ncc_pkg::REG_MAX_PERIOD:     prdata = cfg_q.max_period;
			ncc_pkg::REG_CHANGE_STEP:    prdata = {1'b0, cfg_q.change_step};
			ncc_pkg::REG_LOW_THRESHOLD:  prdata = cfg_q.low_threshold;
			ncc_pkg::REG_HIGH_THRESHOLD: prdata = cfg_q.high_threshold;
			default:                     prdata = '0;
		endcase
	end

endmodule

// ===== sv/ncc_decide.sv =====
// Combinational decision logic: fire or hold for one tick.
// Depends on ncc_pkg for cfg_t and the enable bit positions.
module ncc_decide (
	input  ncc_pkg::cfg_t      cfg,
	input  logic [31:0]        now_seconds,
	input  logic signed [31:0] sample_value,
	input  logic [31:0]        sent_time,
	input  logic signed [31:0] sent_value,
	output logic               fire
);

	logic [32:0]        pmax_due_time;
	logic [32:0]        pmin_end_time;
	logic signed [33:0] val_w;
	logic signed [33:0] sent_w;
	logic signed [33:0] step_w;
	logic               pmax_fire;
	logic               pmin_hold;
	logic               step_hold;
	logic               lt_hold;
	logic               gt_hold;

	// Time sums are one bit wider so they never wrap.
	assign pmax_due_time = {1'b0, sent_time} + {1'b0, cfg.max_period};
	assign pmin_end_time = {1'b0, sent_time} + {1'b0, cfg.min_period};
	assign pmax_fire = cfg.enable_mask[ncc_pkg::EN_PMAX] && (pmax_due_time <= {1'b0, now_seconds});
	assign pmin_hold = cfg.enable_mask[ncc_pkg::EN_PMIN] && (pmin_end_time > {1'b0, now_seconds});

	// The step band is formed at 34 bits, wide enough for both edges.
	assign val_w  = 34'(sample_value);
	assign sent_w = 34'(sent_value);
	assign step_w = $signed({3'b000, cfg.change_step});
	assign step_hold = cfg.enable_mask[ncc_pkg::EN_STEP]
		&& (sent_w + step_w > val_w) && (sent_w - step_w < val_w);

	assign lt_hold = cfg.enable_mask[ncc_pkg::EN_LT]
		&& ((sample_value >= cfg.low_threshold) || (sent_value < cfg.low_threshold));
	assign gt_hold = cfg.enable_mask[ncc_pkg::EN_GT]
		&& ((sample_value <= cfg.high_threshold) || (sent_value > cfg.high_threshold));

	always_comb begin
		priority if (cfg.enable_mask == 5'd0) begin
			fire = 1'b0;
		end else if (pmax_fire) begin
			fire = 1'b1;
		end else begin
			fire = !(pmin_hold || step_hold || lt_hold || gt_hold);
		end
	end

endmodule

// ===== sv/notify_condition_check.sv =====
// Top level of the notification condition check block.
// Depends on ncc_pkg, ncc_if, ncc_cfg_regs and ncc_decide.
//
// Each transfer on the item channel brings a time in seconds and a sample; the
// block answers every one with exactly one transfer on the result channel that
// says whether a notification should go out now. The checks are taken in
// order: with no condition enabled it never fires; an elapsed maximum period
// fires; an unfinished minimum period holds; a sample inside the step band
// around the last sent value holds; a low or high threshold crossing that is
// not new holds; otherwise it fires. When it fires, the sample and the time
// are recorded as the last sent value and time. The block takes one item per
// clock cycle while the item channel is not stalled. An item taken goes into
// the input register; its decision is written from there into the result
// register, from which the result is transferred. The decision logic in front
// of the result register has as its longest path the 34-bit add and compare
// of the step band around the last sent value. The recorded state is updated
// at the same edge as the result register, so the next item always sees it.
// The result register lets a new item enter while a finished result still
// waits to be taken; a stalled result channel stalls the item channel only
// once both registers are full. Registers are to be written over the APB-style
// port only while no item is in flight; the block itself does not enforce it.
// They sit at byte address 4 times their index; pready is always high.
module notify_condition_check (
	input  logic                           clk,
	input  logic                           arst_n,
	ncc_in_if.sink                         item,
	ncc_out_if.source                      result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ncc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ncc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ncc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	ncc_pkg::cfg_t cfg;

	// Input register stage.
	logic               valid_s1;
	logic [31:0]        now_s1;
	logic signed [31:0] sample_s1;

	// Result register and recorded state.
	logic               out_valid_q;
	logic               notify_q;
	logic [31:0]        sent_time_q;
	logic signed [31:0] sent_value_q;

	logic fire;
	logic advance;
	logic commit;

	ncc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ncc_decide u_decide (
		.cfg          (cfg),
		.now_seconds  (now_s1),
		.sample_value (sample_s1),
		.sent_time    (sent_time_q),
		.sent_value   (sent_value_q),
		.fire         (fire)
	);

	// The result register can take a new decision when it is empty or its
	// current result is being transferred in this cycle.
	assign advance = !out_valid_q || result.ready;
	// A decision is final when the input stage holds an item that moves on.
	assign commit = valid_s1 && advance;

	// The input stage is free when empty or when its item moves on now.
	assign item.ready = !valid_s1 || advance;

	assign result.valid  = out_valid_q;
	assign result.notify = notify_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			now_s1    <= item.now_seconds;
			sample_s1 <= item.sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			notify_q <= fire;
		end
	end

	// The last sent time and value start at zero and follow every firing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_time_q  <= '0;
			sent_value_q <= '0;
		end else if (commit && fire) begin
			sent_time_q  <= now_s1;
			sent_value_q <= sample_s1;
		end
	end

endmodule

// ===== sv/ncc_check.sv =====
// Port-level checker for notify_condition_check and its bind statement.
// Depends only on the top level's ports.
module ncc_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_notify
);

	// After reset is sampled low, no result is offered.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_notify))
		else $error("stalled result changed");

	// With the result register empty, the block always takes an item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("item channel stalled with empty result register");

	// An item taken last cycle fills the input stage, so a blocked result stalls input.
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_valid && in_ready) && out_valid && !out_ready |-> !in_ready)
		else $error("item taken while both stages are full");

endmodule

bind notify_condition_check ncc_check u_ncc_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_notify (result.notify)
);
